/* sv/plfk_pkg.sv */
// ----------------------------------------------------------------------------
// plfk_pkg: shared types, constants and functions
// Fixed-point constants, the CORDIC arctangent table and helpers for the
// planar leg forward kinematics block.
// ----------------------------------------------------------------------------
package plfk_pkg;

    localparam int CORDIC_STAGES_DEF = 24;
    localparam int CW                = 33;   // CORDIC x/y/z width
    localparam int RW                = 37;   // position sum width
    localparam int CFG_AW            = 3;
    localparam int CFG_DW            = 31;

    localparam logic [CFG_AW-1:0] REG_BODY     = 3'd0;
    localparam logic [CFG_AW-1:0] REG_UPPER    = 3'd1;
    localparam logic [CFG_AW-1:0] REG_MIDDLE   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_FOOT     = 3'd3;
    localparam logic [CFG_AW-1:0] REG_OVERHANG = 3'd4;

    localparam logic signed [35:0] Q27_PI      = 36'sd421657428;
    localparam logic signed [35:0] Q27_HALF_PI = 36'sd210828714;
    localparam logic signed [35:0] Q27_TWO_PI  = 36'sd843314857;
    localparam logic signed [CW-1:0] Q30_GAIN  = 33'sd652032874;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
    } cordic_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [29:0] th;
        logic signed [30:0] a0;
        logic signed [31:0] a1;
        logic signed [32:0] a2;
    } side_t;

    function automatic logic signed [31:0] atan_q30(input int idx);
        logic signed [31:0] v;
        case (idx)
            0:  v = 32'sh3243F6A8;
            1:  v = 32'sh1DAC6705;
            2:  v = 32'sh0FADBAFC;
            3:  v = 32'sh07F56EA6;
            4:  v = 32'sh03FEAB76;
            5:  v = 32'sh01FFD55B;
            6:  v = 32'sh00FFFAAA;
            7:  v = 32'sh007FFF55;
            8:  v = 32'sh003FFFEA;
            9:  v = 32'sh001FFFFD;
            10: v = 32'sh000FFFFF;
            11: v = 32'sh0007FFFF;
            12: v = 32'sh0003FFFF;
            13: v = 32'sh0001FFFF;
            14: v = 32'sh0000FFFF;
            15: v = 32'sh00007FFF;
            16: v = 32'sh00003FFF;
            17: v = 32'sh00001FFF;
            18: v = 32'sh00000FFF;
            19: v = 32'sh000007FF;
            20: v = 32'sh000003FF;
            21: v = 32'sh000001FF;
            22: v = 32'sh000000FF;
            23: v = 32'sh0000007F;
            24: v = 32'sh0000003F;
            25: v = 32'sh0000001F;
            26: v = 32'sh0000000F;
            27: v = 32'sh00000008;
            28: v = 32'sh00000004;
            29: v = 32'sh00000002;
            30: v = 32'sh00000001;
            default: v = 32'sh00000000;
        endcase
        return v;
    endfunction

    // Bring an angle into [-pi, pi] by a whole number of turns.
    function automatic logic signed [29:0] reduce_angle(input logic signed [32:0] a);
        logic signed [35:0] c;
        logic signed [29:0] r;
        r = '0;
        for (int k = -3; k <= 3; k++) begin
            c = 36'(a) - 36'(k) * Q27_TWO_PI;
            if (c >= -Q27_PI && c <= Q27_PI) begin
                r = c[29:0];
            end
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [RW-1:0] v);
        logic signed [31:0] r;
        if (v > 37'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -37'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* sv/plfk_cordic_cell.sv */
// ----------------------------------------------------------------------------
// plfk_cordic_cell: one CORDIC rotation step
// Rotates the vector by plus or minus atan(2^-STAGE) toward zero residual angle.
// ----------------------------------------------------------------------------
module plfk_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic              aclk,
    input  logic              en,
    input  plfk_pkg::cordic_t d_i,
    output plfk_pkg::cordic_t d_o
);
    import plfk_pkg::*;

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;
    cordic_t              cell_reg;
    cordic_t              cell_next;

    assign dx = d_i.y >>> STAGE;
    assign dy = d_i.x >>> STAGE;
    assign at = CW'(atan_q30(STAGE));

    always_comb begin
        cell_next.flip = d_i.flip;
        if (d_i.z >= 0) begin
            cell_next.x = d_i.x - dx;
            cell_next.y = d_i.y + dy;
            cell_next.z = d_i.z - at;
        end else begin
            cell_next.x = d_i.x + dx;
            cell_next.y = d_i.y - dy;
            cell_next.z = d_i.z + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign d_o = cell_reg;

endmodule

/* sv/plfk_cordic_row.sv */
// ----------------------------------------------------------------------------
// plfk_cordic_row: sine and cosine of one reduced angle
// Folds the angle into the right half plane, runs it through a row of CORDIC
// cells and restores the sign.
// ----------------------------------------------------------------------------
module plfk_cordic_row #(
    parameter int STAGES = plfk_pkg::CORDIC_STAGES_DEF
) (
    input  logic                           aclk,
    input  logic                           en,
    input  logic signed [29:0]             ang,
    output logic signed [plfk_pkg::CW-1:0] sin_o,
    output logic signed [plfk_pkg::CW-1:0] cos_o
);
    import plfk_pkg::*;

    cordic_t              prep_reg;
    cordic_t              prep_next;
    cordic_t              chain [0:STAGES];
    logic signed [35:0]   a;
    logic signed [35:0]   af;
    logic signed [CW-1:0] sin_reg;
    logic signed [CW-1:0] cos_reg;

    always_comb begin
        a              = 36'(ang);
        prep_next.flip = 1'b0;
        af             = a;
        if (a > Q27_HALF_PI) begin
            af             = a - Q27_PI;
            prep_next.flip = 1'b1;
        end else if (a < -Q27_HALF_PI) begin
            af             = a + Q27_PI;
            prep_next.flip = 1'b1;
        end
        prep_next.x = Q30_GAIN;
        prep_next.y = '0;
        prep_next.z = CW'(af <<< 3);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prep_reg <= prep_next;
        end
    end

    assign chain[0] = prep_reg;

    for (genvar i = 0; i < STAGES; i++) begin : g_cell
        plfk_cordic_cell #(.STAGE(i)) u_cell (
            .aclk (aclk),
            .en   (en),
            .d_i  (chain[i]),
            .d_o  (chain[i+1])
        );
    end

    // restore the sign of the folded half plane
    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= chain[STAGES].flip ? -chain[STAGES].y : chain[STAGES].y;
            cos_reg <= chain[STAGES].flip ? -chain[STAGES].x : chain[STAGES].x;
        end
    end

    assign sin_o = sin_reg;
    assign cos_o = cos_reg;

endmodule

/* sv/planar_leg_forward_kinematics.sv */
// ----------------------------------------------------------------------------
// planar_leg_forward_kinematics: three-link planar leg pose
// Computes link centers and absolute angles from a torso pose and joint angles.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the output is not stalled and
// returns one result item for each, in order. The pipeline is made of the
// four parallel CORDIC rows (one per absolute angle: torso, link 0, link 1,
// link 2), each a chain of CORDIC_STAGES cells, plus input, angle reduction,
// fold, sign restore, multiply, round, two add stages and the output register.
// The whole pipeline advances whenever the output register is empty or being
// taken, so s_tready follows m_tready with no bubble. Link lengths come from
// the configuration registers and must only be written while the block is
// idle. Positions are Q16.16 and saturate; angles are Q5.27 radians.
module planar_leg_forward_kinematics #(
    parameter int CORDIC_STAGES = plfk_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [plfk_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [plfk_pkg::CFG_DW-1:0]   cfg_wdata,
    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // torso_x, torso_y, torso_angle, hip_angle, knee_angle, ankle_angle
    input  logic [183:0]                  s_tdata,
    // result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // torso_x_out, torso_y_out, torso_angle_out, link0_center_x,
    // link0_center_y, link0_abs_angle, link1_center_x, link1_center_y,
    // link1_abs_angle, link2_center_x, link2_center_y, link2_abs_angle, 3 zero bits
    output logic [383:0]                  m_tdata
);
    import plfk_pkg::*;

    localparam int LAT = CORDIC_STAGES + 9;
    localparam int MUL = CORDIC_STAGES + 5;

    // configuration registers
    logic [30:0] body_len_reg;
    logic [30:0] upper_len_reg;
    logic [30:0] middle_len_reg;
    logic [30:0] foot_len_reg;
    logic [30:0] overhang_len_reg;

    logic                 adv;
    logic                 valid_reg [0:LAT-1];
    side_t                side_reg  [0:LAT-2];
    side_t                side_next;
    logic signed [29:0]   red_reg   [0:3];
    logic signed [CW-1:0] sin_w     [0:3];
    logic signed [CW-1:0] cos_w     [0:3];
    logic signed [31:0]   mlen      [0:7];
    logic signed [CW-1:0] mtrg      [0:7];
    logic signed [64:0]   prod_reg  [0:7];
    logic signed [RW-1:0] r31_reg   [0:7];
    logic signed [RW-1:0] r30_reg   [2:5];
    // first add stage
    logic signed [RW-1:0] hx_reg, hy_reg, t1x_reg, t1y_reg, t2x_reg, t2y_reg;
    logic signed [RW-1:0] m0x_reg, m0y_reg, oxa_reg, oya_reg;
    // second add stage
    logic signed [RW-1:0] c0x_reg, c0y_reg, c1x_reg, c1y_reg, wx_reg, wy_reg;
    logic signed [RW-1:0] oxb_reg, oyb_reg;
    logic [383:0]         out_reg;
    side_t                so;

    // ---- configuration: take the write, drop unknown indexes -----------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_len_reg     <= '0;
            upper_len_reg    <= '0;
            middle_len_reg   <= '0;
            foot_len_reg     <= '0;
            overhang_len_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_BODY:     body_len_reg     <= cfg_wdata;
                REG_UPPER:    upper_len_reg    <= cfg_wdata;
                REG_MIDDLE:   middle_len_reg   <= cfg_wdata;
                REG_FOOT:     foot_len_reg     <= cfg_wdata;
                REG_OVERHANG: overhang_len_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---- flow control: advance everything when the output can move ------
    assign adv      = !valid_reg[LAT-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = valid_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LAT; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            valid_reg[0] <= s_tvalid;
            for (int k = 1; k < LAT; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // ---- input stage: unpack and form the absolute angles ----------------
    always_comb begin
        side_next.x  = s_tdata[31:0];
        side_next.y  = s_tdata[63:32];
        side_next.th = s_tdata[93:64];
        side_next.a0 = 31'(signed'(s_tdata[93:64])) + 31'(signed'(s_tdata[123:94]));
        side_next.a1 = 32'(side_next.a0) + 32'(signed'(s_tdata[153:124]));
        side_next.a2 = 33'(side_next.a1) + 33'(signed'(s_tdata[183:154]))
                     + 33'(Q27_HALF_PI);
    end

    // hold pose and angles alongside the datapath up to the output
    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side_next;
            for (int k = 1; k < LAT-1; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ---- angle reduction into [-pi, pi] ----------------------------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            red_reg[0] <= reduce_angle(33'(side_reg[0].th));
            red_reg[1] <= reduce_angle(33'(side_reg[0].a0));
            red_reg[2] <= reduce_angle(33'(side_reg[0].a1));
            red_reg[3] <= reduce_angle(side_reg[0].a2);
        end
    end

    // ---- four CORDIC rows ------------------------------------------------
    for (genvar j = 0; j < 4; j++) begin : g_row
        plfk_cordic_row #(.STAGES(CORDIC_STAGES)) u_row (
            .aclk  (aclk),
            .en    (adv),
            .ang   (red_reg[j]),
            .sin_o (sin_w[j]),
            .cos_o (cos_w[j])
        );
    end

    // ---- multiply: lengths by sine and cosine ----------------------------
    always_comb begin
        mlen[0] = 32'(body_len_reg);
        mlen[1] = 32'(body_len_reg);
        mlen[2] = 32'(upper_len_reg);
        mlen[3] = 32'(upper_len_reg);
        mlen[4] = 32'(middle_len_reg);
        mlen[5] = 32'(middle_len_reg);
        mlen[6] = 32'(foot_len_reg) - 32'(overhang_len_reg);
        mlen[7] = mlen[6];
        for (int j = 0; j < 4; j++) begin
            mtrg[2*j]   = sin_w[j];
            mtrg[2*j+1] = cos_w[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 8; j++) begin
                prod_reg[j] <= 65'(mlen[j]) * 65'(mtrg[j]);
            end
        end
    end

    // ---- round half up to Q16.16 (whole and half lengths) ----------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 8; j++) begin
                r31_reg[j] <= RW'((prod_reg[j] + 65'sd1073741824) >>> 31);
            end
            for (int j = 2; j < 6; j++) begin
                r30_reg[j] <= RW'((prod_reg[j] + 65'sd536870912) >>> 30);
            end
        end
    end

    // ---- first add stage: hip point and partial link sums ----------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            hx_reg  <= RW'(side_reg[MUL].x) + r31_reg[0];
            hy_reg  <= RW'(side_reg[MUL].y) - r31_reg[1];
            t1x_reg <= r30_reg[2] + r31_reg[4];
            t1y_reg <= r30_reg[3] + r31_reg[5];
            t2x_reg <= r30_reg[2] + r30_reg[4];
            t2y_reg <= r30_reg[3] + r30_reg[5];
            m0x_reg <= r31_reg[2];
            m0y_reg <= r31_reg[3];
            oxa_reg <= r31_reg[6];
            oya_reg <= r31_reg[7];
        end
    end

    // ---- second add stage: link 0 and link 1 centers, ankle point --------
    always_ff @(posedge aclk) begin
        if (adv) begin
            c0x_reg <= hx_reg + m0x_reg;
            c0y_reg <= hy_reg - m0y_reg;
            c1x_reg <= hx_reg + t1x_reg;
            c1y_reg <= hy_reg - t1y_reg;
            wx_reg  <= hx_reg + t2x_reg;
            wy_reg  <= hy_reg - t2y_reg;
            oxb_reg <= oxa_reg;
            oyb_reg <= oya_reg;
        end
    end

    // ---- output register: saturate and pack ------------------------------
    assign so = side_reg[LAT-2];

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= {3'b000, so.a2[31:0],
                        sat32(wy_reg - oyb_reg), sat32(wx_reg + oxb_reg),
                        so.a1, sat32(c1y_reg), sat32(c1x_reg),
                        so.a0, sat32(c0y_reg), sat32(c0x_reg),
                        so.th, so.y, so.x};
        end
    end

    assign m_tdata = out_reg;

    // ---- checks ----------------------------------------------------------
    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_reset_empties: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled pipeline changed its result");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for planar_leg_forward_kinematics
// Drives torso poses and joint angles in bursts, stalls the result side on a
// rotating pattern, and compares each result item field by field against a
// fixed-point model of the leg held in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_top;
    import plfk_pkg::*;

    localparam longint PI_Q27      = 421657428;
    localparam longint HALF_PI_Q27 = 210828714;
    localparam longint TWO_PI_Q27  = 843314857;
    localparam longint GAIN_Q30    = 652032874;
    localparam int     STAGES      = CORDIC_STAGES_DEF;
    localparam int     LATENCY     = STAGES + 9;

    // fields of one result item, lowest bits first
    typedef struct {
        longint v[12];
    } leg_pose_t;

    // 64-bit floor shift; >>> on longint floors already
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint arctan_entry(int i);
        longint t[32] = '{
            'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
            'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
            'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
            'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
            'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
            'h00000001, 'h00000000};
        return t[i];
    endfunction

    // sine and cosine in Q2.30 of a Q5.27 angle of any size
    task automatic rotate_unit(input longint ang, output longint sn, output longint cs);
        bit     flip;
        longint x, y, z, dx, dy;
        flip = 0;
        x = GAIN_Q30;
        y = 0;
        while (ang > PI_Q27) ang -= TWO_PI_Q27;
        while (ang < -PI_Q27) ang += TWO_PI_Q27;
        if (ang > HALF_PI_Q27) begin
            ang -= PI_Q27;
            flip = 1;
        end else if (ang < -HALF_PI_Q27) begin
            ang += PI_Q27;
            flip = 1;
        end
        z = ang * 8;
        for (int i = 0; i < STAGES && i < 32; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_entry(i);
            end else begin
                x += dx; y -= dy; z += arctan_entry(i);
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endtask

    function automatic longint scale_round(longint len, longint t, int s);
        return floor_shr(len * t + (64'sd1 <<< (s - 1)), s);
    endfunction

    class leg_scoreboard;
        longint    lengths[5];
        leg_pose_t pending[$];
        int        errors;

        function void clear_lengths();
            foreach (lengths[i]) lengths[i] = 0;
        endfunction

        function void set_length(int idx, longint val);
            if (idx < 5) lengths[idx] = val & 64'h7FFFFFFF;
        endfunction

        // work out the leg pose for one accepted input item
        task note_pose(input logic [183:0] d);
            longint x, y, th, q0, q1, q2, a0, a1, a2, off;
            longint st, ct, s0, c0, s1, c1, s2, c2, hx, hy, kx, ky, ex, ey;
            leg_pose_t r;
            x  = longint'($signed(d[31:0]));
            y  = longint'($signed(d[63:32]));
            th = longint'($signed(d[93:64]));
            q0 = longint'($signed(d[123:94]));
            q1 = longint'($signed(d[153:124]));
            q2 = longint'($signed(d[183:154]));
            off = lengths[3] - lengths[4];
            a0 = th + q0;
            a1 = a0 + q1;
            a2 = a1 + q2 + HALF_PI_Q27;
            rotate_unit(th, st, ct);
            rotate_unit(a0, s0, c0);
            rotate_unit(a1, s1, c1);
            rotate_unit(a2, s2, c2);
            hx = x + scale_round(lengths[0], st, 31);
            hy = y - scale_round(lengths[0], ct, 31);
            kx = hx + scale_round(lengths[1], s0, 30);
            ky = hy - scale_round(lengths[1], c0, 30);
            ex = kx + scale_round(lengths[2], s1, 30);
            ey = ky - scale_round(lengths[2], c1, 30);
            r.v[0]  = x;
            r.v[1]  = y;
            r.v[2]  = th;
            r.v[3]  = clamp32(hx + scale_round(lengths[1], s0, 31));
            r.v[4]  = clamp32(hy - scale_round(lengths[1], c0, 31));
            r.v[5]  = a0;
            r.v[6]  = clamp32(kx + scale_round(lengths[2], s1, 31));
            r.v[7]  = clamp32(ky - scale_round(lengths[2], c1, 31));
            r.v[8]  = a1;
            r.v[9]  = clamp32(ex + scale_round(off, s2, 31));
            r.v[10] = clamp32(ey - scale_round(off, c2, 31));
            // link 2 angle wraps at 32 bits
            r.v[11] = longint'($signed(a2[31:0]));
            pending.push_back(r);
        endtask

        function void check_pose(logic [383:0] d);
            string     names[12] = '{"torso_x_out", "torso_y_out", "torso_angle_out",
                "link0_center_x", "link0_center_y", "link0_abs_angle",
                "link1_center_x", "link1_center_y", "link1_abs_angle",
                "link2_center_x", "link2_center_y", "link2_abs_angle"};
            int        widths[12] = '{32, 32, 30, 32, 32, 31, 32, 32, 32, 32, 32, 32};
            int        pos;
            longint    got;
            leg_pose_t e;
            if (pending.size() == 0) begin
                $error("unexpected result item %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            pos = 0;
            for (int f = 0; f < 12; f++) begin
                got = 0;
                for (int b = 0; b < widths[f]; b++) got[b] = d[pos + b];
                for (int b = widths[f]; b < 64; b++) got[b] = got[widths[f] - 1];
                if (got != e.v[f]) begin
                    $error("%s: expected %0d, got %0d", names[f], e.v[f], got);
                    errors++;
                end
                pos += widths[f];
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_AW-1:0]    cfg_addr;
    logic [CFG_DW-1:0]    cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [183:0]         s_tdata;    // torso_x, torso_y, torso/hip/knee/ankle angles
    logic                 m_tvalid;
    logic                 m_tready;
    logic [383:0]         m_tdata;    // twelve result fields, 3 zero bits on top

    leg_scoreboard board;
    bit            stall_on;

    planar_leg_forward_kinematics DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        aclk = 1'b0; #5;
        aclk = 1'b1; #5;
    end

    // Check every result item at the edge that moves it.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_pose(m_tdata);
    end

    // Receiver: stall in a rotating pattern, with quiet stretches where it never stalls.
    initial begin
        int phase;
        phase = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            phase++;
            if (!stall_on || (phase % 97) < 30) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ((phase * 7) % 11) > 3;
            end
        end
    end

    // Write one register, then drop the enable.
    task automatic write_length(logic [CFG_AW-1:0] idx, longint val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[CFG_DW-1:0];
        @(posedge aclk);
        board.set_length(idx, val);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    // Hold one item until taken; valid stays high across back-to-back items when keep_valid is set.
    task automatic send_pose(logic [183:0] d, bit keep_valid);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        board.note_pose(d);
        if (!keep_valid) s_tvalid <= 1'b0;
    endtask

    function automatic logic [29:0] rand_angle(int mode);
        case (mode)
            0: return 30'($signed($urandom_range(0, 843314856)) - 421657428);
            1: return 30'($urandom());                // full field, beyond pi
            default: return 30'($signed($urandom_range(0, 6000)) - 3000);
        endcase
    endfunction

    function automatic logic [183:0] pack_pose(logic [31:0] x, logic [31:0] y,
            logic [29:0] th, logic [29:0] q0, logic [29:0] q1, logic [29:0] q2);
        return {q2, q1, q0, th, y, x};
    endfunction

    task automatic send_random(int count, bit gaps);
        int left, burst;
        logic [183:0] d;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst && left > 0; i++) begin
                d = pack_pose($urandom(), $urandom(), rand_angle($urandom_range(0, 3)),
                    rand_angle($urandom_range(0, 3)), rand_angle($urandom_range(0, 3)),
                    rand_angle($urandom_range(0, 3)));
                if (($urandom_range(0, 3)) == 0) d[63:0] = {$urandom_range(0, 2000),
                    $urandom_range(0, 2000)};
                left--;
                send_pose(d, !gaps || (i + 1 < burst && left > 0));
            end
            if (gaps) repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic random_lengths(bit wide);
        for (int r = 0; r < 5; r++) begin
            write_length(r[CFG_AW-1:0], wide ? longint'($urandom()) & 64'h7FFFFFFF
                : longint'($urandom_range(0, 32'h00200000)));
        end
    endtask

    initial begin
        longint ext[6];
        board     = new();
        board.clear_lengths();
        stall_on  = 0;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset lengths are zero: everything collapses onto the torso point.
        send_pose(pack_pose(32'h00010000, 32'hFFFF0000, 30'd0, 30'd0, 30'd0, 30'd0), 0);
        drain();

        // Moderate leg, overhang shorter than foot; walk the angle extremes.
        write_length(REG_BODY,     64'h00020000);
        write_length(REG_UPPER,    64'h00010000);
        write_length(REG_MIDDLE,   64'h00018000);
        write_length(REG_FOOT,     64'h00008000);
        write_length(REG_OVERHANG, 64'h00002000);
        write_length(3'd7,         64'h12345678);   // no such register: ignored
        ext = '{421657428, -421657428, 210828714, -210828714, 0, 1};
        foreach (ext[i]) begin
            send_pose(pack_pose(32'h7FFFFFFF, 32'h80000000, 30'(ext[i]), 30'(ext[i]),
                30'(ext[i]), 30'(ext[i])), 1);
        end
        send_pose(pack_pose('0, '0, 30'h1FFFFFFF, 30'h1FFFFFFF, 30'h1FFFFFFF,
            30'h1FFFFFFF), 1);   // angles beyond pi, sum wraps
        send_pose(pack_pose('1, '1, 30'h20000000, 30'h20000000, 30'h20000000,
            30'h20000000), 1);
        send_pose(pack_pose(32'h80000000, 32'h7FFFFFFF, 30'(421657428), 30'(-421657428),
            30'(421657428), 30'(-421657428)), 0);
        drain();

        // Overhang longer than foot, longest lengths: saturation near the rails.
        write_length(REG_BODY,     64'h7FFFFFFF);
        write_length(REG_UPPER,    64'h7FFFFFFF);
        write_length(REG_MIDDLE,   64'h7FFFFFFF);
        write_length(REG_FOOT,     64'h0);
        write_length(REG_OVERHANG, 64'h7FFFFFFF);
        foreach (ext[i]) begin
            send_pose(pack_pose(32'h7FFFFFFF, 32'h80000000, 30'(ext[i]), 30'(-ext[i]),
                30'(ext[i]), 30'(ext[i])), 1);
        end
        send_pose(pack_pose('0, '0, '0, '0, '0, '0), 0);
        drain();

        // Random phases under several length settings, with stalls and gaps.
        stall_on = 1;
        send_random(150, 1);
        drain();
        random_lengths(0);
        send_random(150, 0);
        drain();
        random_lengths(1);
        send_random(150, 1);
        drain();
        random_lengths(0);
        write_length(REG_OVERHANG, 64'h7FFFFFFF);
        send_random(150, 1);
        drain();
        random_lengths(1);
        send_random(150, 1);
        drain();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
